// File: design/quaternion_to_euler_assert.svh
// assertion macros for the quaternion to euler block
// used by the port checker, no other dependencies
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qte assertion failed");

// next-cycle implication, disabled in reset
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qte assertion failed");

`endif

// File: design/qte_pkg.sv
// shared widths, constants and helpers for the quaternion to euler block
// no dependencies
package qte_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int TABLE_LEN         = 24;

   localparam int XY_W   = 38;   // cordic vector width
   localparam int Z_W    = 36;   // q30 angle accumulator
   localparam int ANG_W  = 38;   // angle before rounding
   localparam int SQ_IN_W   = 38; // radicand, q32
   localparam int SQ_ROOT_W = 19; // one root bit per stage
   localparam int SQ_REM_W  = 22;

   localparam logic signed [Z_W-1:0]   PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
   localparam logic signed [15:0] PITCH_LIMIT = 16'sd12868;

   localparam logic [30:0] ATAN_TAB [TABLE_LEN] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
      31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
      31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
      31'd127};

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;

   // q30 to q13 with round half up, then saturate
   function automatic logic signed [15:0] round_clamp(input logic signed [ANG_W-1:0] v,
                                                      input logic signed [15:0] lim);
      logic signed [ANG_W-1:0] s;
      logic signed [20:0] r;
      logic signed [20:0] l;
      s = v + 38'sd65536;
      r = 21'(s >>> 17);
      l = 21'(lim);
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return 16'(r);
   endfunction

endpackage

// File: design/qte_cordic.sv
// pipelined vectoring cordic, one stage per iteration, gives atan2(y, x) in q30
// depends on qte_pkg
module qte_cordic #(
   parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  qte_pkg::xy_type     y_in,
   input  qte_pkg::xy_type     x_in,
   output qte_pkg::z_type      z_out
);
   import qte_pkg::*;

   xy_type x_ff [STAGES+1];
   xy_type y_ff [STAGES+1];
   z_type  z_ff [STAGES+1];

   // left half plane: negate and start at plus or minus pi
   always_ff @(posedge clock) begin
      if (en) begin
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in < 0) ? -PI_Q30 : PI_Q30;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      xy_type xs, ys;
      z_type  da;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign da = signed'(Z_W'(ATAN_TAB[i]));
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + da;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - da;
            end
         end
      end
   end

   assign z_out = z_ff[STAGES];

endmodule

// File: design/quaternion_to_euler.sv
// quaternion to zyx euler angles: CORDIC_STAGES + 24 register stages, and rsp_tvalid
// follows the last valid bit; throughput one item per cycle unless the output stalls
// the 19-stage square root and the cordic rows set the depth
// every register stage moves together while the output is free or being taken
// reset (synchronous, active high) clears only the valid bits of the pipeline
// depends on qte_pkg and qte_cordic
module quaternion_to_euler #(
   parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
   parameter int SAMPLE_WIDTH  = qte_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // roll_angle 16, pitch_angle 15, yaw_angle 16, zero pad
);
   import qte_pkg::*;

   localparam int TOTAL = 3 + SQ_ROOT_W + CORDIC_STAGES + 2;

   logic adv;
   logic [TOTAL-1:0] vld_ff;
   logic [TOTAL-1:0] vld_in;

   // whole pipe advances when the output register is empty or drained
   assign adv        = !vld_ff[TOTAL-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[TOTAL-1];
   assign vld_in     = {vld_ff[TOTAL-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // sample read: low SAMPLE_WIDTH bits, brought to q2.14
   logic signed [15:0] q_in [4];
   for (genvar k = 0; k < 4; k++) begin : g_read
      logic signed [SAMPLE_WIDTH-1:0] smp;
      assign smp = signed'(SAMPLE_WIDTH'(req_tdata[16*k +: 16]));
      if (SAMPLE_WIDTH >= 16) begin : g_down
         assign q_in[k] = 16'(smp >>> (SAMPLE_WIDTH - 16));
      end else begin : g_up
         assign q_in[k] = {smp, {(16 - SAMPLE_WIDTH){1'b0}}};
      end
   end

   // stage 1: registered samples
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= q_in[0];
         x_ff <= q_in[1];
         y_ff <= q_in[2];
         z_ff <= q_in[3];
      end
   end

   // stage 2: exact q4.28 products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= w_ff * x_ff;
         yz_ff <= y_ff * z_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         wz_ff <= w_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         zz_ff <= z_ff * z_ff;
         wy_ff <= w_ff * y_ff;
         xz_ff <= x_ff * z_ff;
      end
   end

   // stage 3: atan2 arguments and clamped radicands
   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
   logic signed [35:0] sr_in, cr_in, sy_in, cy_in, t_in, a_in, b_in;
   logic signed [35:0] sr_ff, cr_ff, sy_ff, cy_ff;
   logic [33:0] a_ff, b_ff;

   always_comb begin
      sr_in = (36'(wx_ff) + 36'(yz_ff)) <<< 1;
      cr_in = ONE_Q28 - ((36'(xx_ff) + 36'(yy_ff)) <<< 1);
      sy_in = (36'(wz_ff) + 36'(xy_ff)) <<< 1;
      cy_in = ONE_Q28 - ((36'(yy_ff) + 36'(zz_ff)) <<< 1);
      t_in  = 36'(wy_ff) - 36'(xz_ff);
      a_in  = ONE_Q28 + (t_in <<< 1);
      b_in  = ONE_Q28 - (t_in <<< 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_ff <= sr_in;
         cr_ff <= cr_in;
         sy_ff <= sy_in;
         cy_ff <= cy_in;
         a_ff  <= (a_in < 0) ? '0 : a_in[33:0];
         b_ff  <= (b_in < 0) ? '0 : b_in[33:0];
      end
   end

   // two digit-by-digit square roots, one root bit per stage, radicand in q32
   // index s holds the state after stage s
   logic [SQ_REM_W-1:0]  rem_ff  [2][SQ_ROOT_W];
   logic [SQ_ROOT_W-1:0] root_ff [2][SQ_ROOT_W];
   logic [SQ_IN_W-1:0]   rad_ff  [2][SQ_ROOT_W];
   logic signed [35:0]   dsr_ff [SQ_ROOT_W];
   logic signed [35:0]   dcr_ff [SQ_ROOT_W];
   logic signed [35:0]   dsy_ff [SQ_ROOT_W];
   logic signed [35:0]   dcy_ff [SQ_ROOT_W];

   for (genvar s = 0; s < SQ_ROOT_W; s++) begin : g_sqrt
      for (genvar u = 0; u < 2; u++) begin : g_unit
         logic [SQ_REM_W-1:0]  rem_cur, r2, trial;
         logic [SQ_ROOT_W-1:0] root_cur;
         logic [SQ_IN_W-1:0]   rad_cur;
         if (s == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = (u == 0) ? {a_ff, 4'b0000} : {b_ff, 4'b0000};
         end else begin : g_next
            assign rem_cur  = rem_ff[u][s-1];
            assign root_cur = root_ff[u][s-1];
            assign rad_cur  = rad_ff[u][s-1];
         end
         assign r2    = {rem_cur[SQ_REM_W-3:0], rad_cur[SQ_IN_W-1 -: 2]};
         assign trial = SQ_REM_W'({root_cur, 2'b01});
         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[u][s] <= {rad_cur[SQ_IN_W-3:0], 2'b00};
               if (r2 >= trial) begin
                  rem_ff[u][s]  <= r2 - trial;
                  root_ff[u][s] <= {root_cur[SQ_ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff[u][s]  <= r2;
                  root_ff[u][s] <= {root_cur[SQ_ROOT_W-2:0], 1'b0};
               end
            end
         end
      end
      // roll and yaw arguments wait beside the roots
      if (s == 0) begin : g_arg_first
         always_ff @(posedge clock) begin
            if (adv) begin
               dsr_ff[s] <= sr_ff;
               dcr_ff[s] <= cr_ff;
               dsy_ff[s] <= sy_ff;
               dcy_ff[s] <= cy_ff;
            end
         end
      end else begin : g_arg_next
         always_ff @(posedge clock) begin
            if (adv) begin
               dsr_ff[s] <= dsr_ff[s-1];
               dcr_ff[s] <= dcr_ff[s-1];
               dsy_ff[s] <= dsy_ff[s-1];
               dcy_ff[s] <= dcy_ff[s-1];
            end
         end
      end
   end

   // three cordic rows in lockstep
   z_type z_roll, z_pitch, z_yaw;

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock),
      .en    (adv),
      .y_in  (XY_W'(dsr_ff[SQ_ROOT_W-1])),
      .x_in  (XY_W'(dcr_ff[SQ_ROOT_W-1])),
      .z_out (z_roll)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock),
      .en    (adv),
      .y_in  (signed'(XY_W'(root_ff[0][SQ_ROOT_W-1]))),
      .x_in  (signed'(XY_W'(root_ff[1][SQ_ROOT_W-1]))),
      .z_out (z_pitch)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock),
      .en    (adv),
      .y_in  (XY_W'(dsy_ff[SQ_ROOT_W-1])),
      .x_in  (XY_W'(dcy_ff[SQ_ROOT_W-1])),
      .z_out (z_yaw)
   );

   // output register: round to q13 and saturate
   logic signed [ANG_W-1:0] pitch_q30;
   logic signed [15:0] roll_in, pitch_in, yaw_in;
   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;

   assign pitch_q30 = (ANG_W'(z_pitch) <<< 1) - HALF_PI_Q30;
   assign roll_in   = round_clamp(ANG_W'(z_roll), ANGLE_LIMIT);
   assign pitch_in  = round_clamp(pitch_q30, PITCH_LIMIT);
   assign yaw_in    = round_clamp(ANG_W'(z_yaw), ANGLE_LIMIT);

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in[14:0];
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_tdata = {1'b0, yaw_ff, pitch_ff, roll_ff};

endmodule

// File: design/qte_checker.sv
// port-level checks for the quaternion to euler block, bound to the top level
// depends on quaternion_to_euler_assert.svh
`include "quaternion_to_euler_assert.svh"

module qte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a held result blocks new input
   `QTE_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // an untaken item stays
   `QTE_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `QTE_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[47] == 1'b0)
   `QTE_ASSERT_NOW(a_pitch_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata[30:16]) <= 15'sd12868 && $signed(rsp_tdata[30:16]) >= -15'sd12868)
   `QTE_ASSERT_NOW(a_roll_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata[15:0]) <= 16'sd25736 && $signed(rsp_tdata[15:0]) >= -16'sd25736)

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_quaternion_to_euler.sv
// self-checking testbench for quaternion_to_euler: directed table, then random quaternions
// depends on qte_pkg and the quaternion_to_euler rtl; predicts each result in-line
`timescale 1ns / 100ps

module tb_quaternion_to_euler;

   localparam int STAGES     = qte_pkg::CORDIC_STAGES_DEF;
   localparam int N_RANDOM   = 1800;
   localparam int STALL_LIM  = 5000;  // cycles with no item moving before we give up
   localparam int DRAIN_WAIT = 60;    // a bit past the CORDIC_STAGES + 24 pipeline depth

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
   } euler_type;

   typedef struct {
      logic [15:0] w, x, y, z;
      bit          known;     // roll and yaw typed in, pitch from the predictor
      logic signed [15:0] roll, yaw;
   } quat_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // quat_w, quat_x, quat_y, quat_z from the low bits up
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // roll_angle, pitch_angle, yaw_angle, one zero pad bit

   euler_type angles_due[$];
   int     err_count   = 0;
   int     n_sent      = 0;
   int     n_checked   = 0;
   int     idle_cycles = 0;
   bit     quiet       = 1'b0;     // no idling on either side
   bit     hold_req    = 1'b0;     // asks the receiver for one long hold-off
   bit     finishing   = 1'b0;

   quaternion_to_euler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor: exact products, floor square roots, vectoring cordic
   // ---------------------------------------------------------------------

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root   = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v    = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos >>= 2;
      end
      return longint'(root);
   endfunction

   // q30 angle of the vector (xv, yv)
   function automatic longint vector_angle(longint yv, longint xv);
      longint acc;
      longint xs, ys;
      acc = 0;
      if (xv < 0) begin
         // left half plane: flip the vector, start from +-pi
         acc = (yv < 0) ? -longint'(qte_pkg::PI_Q30) : longint'(qte_pkg::PI_Q30);
         xv  = -xv;
         yv  = -yv;
      end
      for (int i = 0; i < STAGES && i < qte_pkg::TABLE_LEN; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv >= 0) begin
            xv  = xv + ys;
            yv  = yv - xs;
            acc = acc + longint'(qte_pkg::ATAN_TAB[i]);
         end else begin
            xv  = xv - ys;
            yv  = yv + xs;
            acc = acc - longint'(qte_pkg::ATAN_TAB[i]);
         end
      end
      return acc;
   endfunction

   // q30 to q13, round half up, saturate at +-lim
   function automatic longint angle_q13(longint a30, longint lim);
      longint r;
      r = (a30 + 65536) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type predict_euler(logic [15:0] qw, logic [15:0] qx,
                                               logic [15:0] qy, logic [15:0] qz);
      longint w, x, y, z, one, sr, cr, sy, cy, t, a, b, sa, sb;
      euler_type e;
      w   = longint'($signed(qw));
      x   = longint'($signed(qx));
      y   = longint'($signed(qy));
      z   = longint'($signed(qz));
      one = 64'sd1 << 28;
      sr  = 2 * (w * x + y * z);
      cr  = one - 2 * (x * x + y * y);
      sy  = 2 * (w * z + x * y);
      cy  = one - 2 * (y * y + z * z);
      t   = w * y - x * z;
      // non-unit input: clamp the radicands at zero
      a   = one + 2 * t;
      b   = one - 2 * t;
      if (a < 0) a = 0;
      if (b < 0) b = 0;
      sa  = floor_sqrt(longint'(a) << 4);
      sb  = floor_sqrt(longint'(b) << 4);
      e.roll  = 16'(angle_q13(vector_angle(sr, cr), 25736));
      e.pitch = 15'(angle_q13(2 * vector_angle(sa, sb) - longint'(qte_pkg::HALF_PI_Q30),
                              12868));
      e.yaw   = 16'(angle_q13(vector_angle(sy, cy), 25736));
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one item onto the request channel, waits for acceptance
   task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, bit known, logic signed [15:0] roll_typed,
                            logic signed [15:0] yaw_typed);
      euler_type e;
      if (!quiet) begin
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e = predict_euler(w, x, y, z);
      if (known) begin
         e.roll = roll_typed;
         e.yaw  = yaw_typed;
      end
      angles_due.push_back(e);
      n_sent++;
   endtask

   // random direction scaled to unit length in q2.14
   task automatic unit_quat(output logic [15:0] q [4]);
      real c [4];
      real norm;
      do begin
         norm = 0.0;
         for (int i = 0; i < 4; i++) begin
            c[i] = (real'($urandom_range(65534)) - 32767.0) / 32767.0;
            norm = norm + c[i] * c[i];
         end
      end while (norm < 1.0e-4);
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(c[i] * 16384.0 / norm));
   endtask

   // ---------------------------------------------------------------------
   // directed table: zero, identity, axis rotations, gimbal lock, extremes
   // ---------------------------------------------------------------------

   quat_row_type dir_rows [] = '{
      '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'sd0, 16'sd0}, // identity
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'sd0, 16'sd0}, // all zero
      '{16'hc000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'sd0, 16'sd0}, // minus identity
      '{16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0}, // half turn about x
      '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0, 16'sd0, 16'sd0},
      '{16'h2d41, 16'h2d41, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0}, // quarter turn x
      '{16'h2d41, 16'h0000, 16'h0000, 16'hd2bf, 1'b0, 16'sd0, 16'sd0}, // quarter turn -z
      '{16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 1'b0, 16'sd0, 16'sd0}, // gimbal lock up
      '{16'h2d41, 16'h0000, 16'hd2bf, 16'h0000, 1'b0, 16'sd0, 16'sd0}, // gimbal lock down
      '{16'h0000, 16'hc000, 16'h0001, 16'h0000, 1'b0, 16'sd0, 16'sd0}, // left half plane
      '{16'h0000, 16'hc000, 16'hffff, 16'h0000, 1'b0, 16'sd0, 16'sd0},
      '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 16'sd0, 16'sd0}, // far from unit
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'sd0, 16'sd0},
      '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0, 16'sd0, 16'sd0}, // far from unit, t near zero
      '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, 16'sd0, 16'sd0}, // far from unit, t of zero
      '{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, 16'sd0, 16'sd0},
      '{16'h0001, 16'hffff, 16'h0001, 16'hffff, 1'b0, 16'sd0, 16'sd0}  // tiny values
   };

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      logic [15:0] q [4];
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_quat(dir_rows[i].w, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                   dir_rows[i].known, dir_rows[i].roll, dir_rows[i].yaw);

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= 600 && n < 900);
         // receiver holds off while we keep offering items
         if (n == 300) hold_req = 1'b1;
         // sender pause: let the pipeline empty out completely
         if (n == 1200) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (angles_due.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            unit_quat(q);
         end else if (pick < 80) begin
            // near gimbal lock: y equal to w or to its negation, small x and z
            q[0] = 16'sd11585 + 16'($urandom_range(40)) - 16'sd20;
            q[2] = ($urandom_range(1) != 0) ? q[0] : -q[0];
            q[1] = 16'($urandom_range(64)) - 16'sd32;
            q[3] = 16'($urandom_range(64)) - 16'sd32;
         end else begin
            for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
         end
         send_quat(q[0], q[1], q[2], q[3], 1'b0, 16'sd0, 16'sd0);
      end
      req_tvalid <= 1'b0;

      finishing = 1'b1;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d quaternions (directed, unit, gimbal lock, raw noise), %0d checked",
               n_sent, n_checked);
      if (err_count == 0 && angles_due.size() == 0) begin
         $display("[quaternion_to_euler] OK");
      end else begin
         $display("[quaternion_to_euler] ERROR");
      end
      $finish;
   end

   // receiver: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req && idle_cycles == 0) begin
         idle_cycles = 300;
         hold_req    = 1'b0;
      end
      if (idle_cycles > 0) begin
         idle_cycles = idle_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 13);
      end
   end

   // result checker
   always @(posedge clock) begin
      euler_type e;
      logic signed [15:0] got_roll, got_yaw;
      logic signed [14:0] got_pitch;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_roll  = rsp_tdata[15:0];
         got_pitch = rsp_tdata[30:16];
         got_yaw   = rsp_tdata[46:31];
         if (angles_due.size() == 0) begin
            $display("%0t: unexpected item roll %0d pitch %0d yaw %0d", $time,
                     got_roll, got_pitch, got_yaw);
            err_count++;
         end else begin
            e = angles_due.pop_front();
            n_checked++;
            if (got_roll !== e.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, e.roll, got_roll);
               err_count++;
            end
            if (got_pitch !== e.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, got_pitch);
               err_count++;
            end
            if (got_yaw !== e.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, got_yaw);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles in which no item moves on either channel
   always @(posedge clock) begin
      int stalled;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stalled = 0;
      end else begin
         stalled = stalled + 1;
         if (stalled >= STALL_LIM) begin
            $display("%0t: timeout, %0d results outstanding", $time, angles_due.size());
            $display("[quaternion_to_euler] ERROR");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
+incdir+design
design/qte_pkg.sv
design/qte_cordic.sv
design/quaternion_to_euler.sv
design/qte_checker.sv
test/tb_quaternion_to_euler.sv
